>>> src/fst_pkg.sv
// Shared types and codes for the first-free slot table.
`default_nettype none

package fst_pkg;

  // Operation codes carried in the low bits of an input word.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Width of the reported slot index; larger tables report it modulo 16.
  localparam int IDX_BITS = 4;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CLEARED   = 3'd4,
    ST_IGNORED   = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SEARCH
  } fsm_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic                live;
    logic                ins;
    logic                found;
    logic [IDX_BITS-1:0] idx;
  } tok_t;

endpackage

`default_nettype wire

>>> src/fst_cell.sv
// One slot of the table together with its stage of the search token chain.
`default_nettype none

module fst_cell
  import fst_pkg::*;
#(
  parameter int HANDLE_BITS = 32,
  parameter int IDX         = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   clr,
  input  wire logic [HANDLE_BITS-1:0] handle,
  input  wire tok_t                   tok_in,
  output tok_t                        tok_out
);

  logic [HANDLE_BITS-1:0] slot;
  logic [HANDLE_BITS-1:0] slot_next;
  tok_t                   tok_next;

  always_comb begin
    slot_next = slot;
    tok_next  = tok_in;
    if (clr) begin
      slot_next = '0;
    end else if (tok_in.live && !tok_in.found) begin
      if (tok_in.ins && (slot == '0)) begin
        slot_next      = handle;
        tok_next.found = 1'b1;
        tok_next.idx   = IDX_BITS'(IDX);
      end else if (!tok_in.ins && (slot == handle)) begin
        slot_next      = '0;
        tok_next.found = 1'b1;
        tok_next.idx   = IDX_BITS'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      tok_out <= '0;
    end else begin
      slot    <= slot_next;
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

>>> src/first_free_slot_table.sv
// Top level of the first-free slot table: stream ports, control and the cell chain.
`default_nettype none

// The table holds SLOT_COUNT handle slots, one per cell, with zero marking an
// empty slot; all slots are empty after reset. Each input word carries an
// operation and a handle and yields exactly one result word. Clear, an insert
// of a zero handle, a remove of a zero handle and the unused operation code
// are answered at once: the result word is registered at the edge that
// accepts the input word and is offered in the next cycle. An insert or
// remove of a nonzero handle launches a token that walks down the chain of
// cells one cell per clock; the first cell that can take it (an empty slot for
// insert, a matching slot for remove) claims it, so lowest-slot-first order
// falls out of the walk. Such a word passes from acceptance through the
// launch register and the register of each cell of the chain to the result
// register. One word is in work at a time; the next input word is taken
// once the previous result has been registered and the output register is
// free or being emptied, so immediate words can follow each other every
// cycle.

module first_free_slot_table
  import fst_pkg::*;
#(
  parameter int SLOT_COUNT  = 16,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // operation [1:0], handle [33:2], zero fill
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // status [2:0], slot_index [6:3], zero fill
);

  fsm_t                   state;
  fsm_t                   state_next;
  logic [1:0]             op_in;
  logic [HANDLE_BITS-1:0] h_in;
  logic                   accept;
  logic                   clr;
  logic                   go;
  logic                   imm;
  status_t                imm_status;
  tok_t                   launch;
  tok_t                   chain [SLOT_COUNT+1];
  tok_t                   tail;
  logic [HANDLE_BITS-1:0] hold_handle;
  logic                   out_valid;
  status_t                out_status;
  logic [IDX_BITS-1:0]    out_idx;

  assign op_in = s_tdata[1:0];

  // Only the low HANDLE_BITS bits of the handle field take part.
  if (HANDLE_BITS >= 32) begin : g_wide
    assign h_in = HANDLE_BITS'(s_tdata[33:2]);
  end else begin : g_narrow
    assign h_in = s_tdata[2 +: HANDLE_BITS];
  end

  assign s_tready = (state == FSM_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign tail     = chain[SLOT_COUNT];

  // Decide whether the word is answered at once or needs a walk down the chain.
  always_comb begin
    go         = 1'b0;
    imm        = 1'b0;
    clr        = 1'b0;
    imm_status = ST_IGNORED;
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_INSERT: begin
              if (h_in == '0) begin
                imm        = 1'b1;
                imm_status = ST_IGNORED;
              end else begin
                go = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (h_in == '0) begin
                imm        = 1'b1;
                imm_status = ST_NOT_FOUND;
              end else begin
                go = 1'b1;
              end
            end
            OP_CLEAR: begin
              imm        = 1'b1;
              clr        = 1'b1;
              imm_status = ST_CLEARED;
            end
            default: begin
              imm        = 1'b1;
              imm_status = ST_IGNORED;
            end
          endcase
          if (go) begin
            state_next = FSM_SEARCH;
          end
        end
      end
      FSM_SEARCH: begin
        if (tail.live) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FSM_IDLE;
      launch <= '0;
    end else begin
      state  <= state_next;
      launch <= '{live: go, ins: (op_in == OP_INSERT), found: 1'b0, idx: '0};
    end
  end

  // The handle stays put while the token walks; every cell compares against it.
  always_ff @(posedge clk) begin
    if (go) begin
      hold_handle <= h_in;
    end
  end

  assign chain[0] = launch;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    fst_cell #(
      .HANDLE_BITS (HANDLE_BITS),
      .IDX         (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clr     (clr),
      .handle  (hold_handle),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // Output register. A token leaving the chain always finds it free, since the
  // word was only taken while the register was free or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (imm) begin
        out_valid  <= 1'b1;
        out_status <= imm_status;
        out_idx    <= '0;
      end else if (tail.live) begin
        out_valid <= 1'b1;
        if (tail.found) begin
          out_status <= tail.ins ? ST_INSERTED : ST_REMOVED;
          out_idx    <= tail.idx;
        end else begin
          out_status <= tail.ins ? ST_FULL : ST_NOT_FOUND;
          out_idx    <= '0;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_idx, out_status};

endmodule

`default_nettype wire
